[rtl/mrrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrc_pkg: shared types and constants of the ripple rotation counter
// Item formats, queue entry, configuration set, register indexes and reset
// values used by all files of the block.
// ----------------------------------------------------------------------------
package mrrc_pkg;

  // field widths
  localparam int RIPPLE_W   = 16;
  localparam int PERIOD_W   = 16;
  localparam int THR_W      = 16;
  localparam int IGNORE_W   = 16;
  localparam int PPR_W      = 6;
  localparam int TIMEOUT_W  = 24;
  localparam int REV_W      = 32;
  localparam int SPEED_W    = 24;
  localparam int PTIME_W    = 24;
  localparam int RTIME_W    = 32;
  localparam int DIVIDEND_W = 32;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  // default history length and queue depth
  localparam int HISTORY_LEN_DEF = 4;
  localparam int QUEUE_DEPTH     = 2;

  // revolutions per second times 256, per microsecond of revolution time
  localparam longint unsigned SPEED_SCALE = 64'd256000000;
  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  // operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RIPPLE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_IGNORE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_REV   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_TIMEOUT     = 2'd3;

  // configuration reset values
  localparam logic signed [THR_W-1:0] THR_RESET     = -16'sd30;
  localparam logic [IGNORE_W-1:0]     IGNORE_RESET  = 16'd500;
  localparam logic [PPR_W-1:0]        PPR_RESET     = 6'd6;
  localparam logic [TIMEOUT_W-1:0]    TIMEOUT_RESET = 24'd100000;

  typedef struct packed {
    logic                     op;
    logic signed [RIPPLE_W-1:0] ripple_ma;
    logic [PERIOD_W-1:0]      elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic [REV_W-1:0]   total_revs;
    logic [REV_W-1:0]   revs_since_read;
    logic [SPEED_W-1:0] speed_rps_q8;
    logic               pulse_seen;
    logic               rev_done;
  } out_item_t;

  typedef struct packed {
    logic signed [THR_W-1:0] ripple_threshold_ma;
    logic [IGNORE_W-1:0]     pulse_ignore_us;
    logic [PPR_W-1:0]        pulses_per_rev;
    logic [TIMEOUT_W-1:0]    stop_timeout_us;
  } cfg_t;

  typedef enum logic {
    CMD_SAMPLE,
    CMD_READ
  } cmd_kind_t;

  // classified item as it travels through the queue
  typedef struct packed {
    cmd_kind_t           kind;
    logic                below_thr;
    logic                above_zero;
    logic [PERIOD_W-1:0] elapsed_us;
  } cmd_t;

  typedef struct packed {
    logic               done;
    logic [SPEED_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic {
    BK_RUN,
    BK_DIV
  } back_state_t;

endpackage

[rtl/mrrc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrc_in_if: input item channel
// Valid/ready channel carrying one sample or read request.
// ----------------------------------------------------------------------------
interface mrrc_in_if;
  logic                valid;
  logic                ready;
  mrrc_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/mrrc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrc_out_if: result item channel
// Valid/ready channel carrying one result per input item.
// ----------------------------------------------------------------------------
interface mrrc_out_if;
  logic                valid;
  logic                ready;
  mrrc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/mrrc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrc_front: input stage
// Accepts items, decodes the operation and compares the sample against the
// arming threshold and zero, then hands the classified item to the queue.
// ----------------------------------------------------------------------------
module mrrc_front (
  input  logic                clk,
  input  logic                rst,
  mrrc_in_if.sink             in_ch,
  input  mrrc_pkg::cfg_t      cfg,
  output logic                push,
  output mrrc_pkg::cmd_t      push_data,
  input  logic                full
);

  logic           hold_valid;
  mrrc_pkg::cmd_t hold;
  mrrc_pkg::cmd_t cls;
  logic           take;

  // classification of the incoming item
  always_comb begin
    cls.kind       = (in_ch.data.op == mrrc_pkg::OP_READ) ? mrrc_pkg::CMD_READ
                                                          : mrrc_pkg::CMD_SAMPLE;
    cls.below_thr  = in_ch.data.ripple_ma < cfg.ripple_threshold_ma;
    cls.above_zero = in_ch.data.ripple_ma > 16'sd0;
    cls.elapsed_us = in_ch.data.elapsed_us;
  end

  assign push        = hold_valid && !full;
  assign in_ch.ready = !hold_valid || !full;
  assign take        = in_ch.valid && in_ch.ready;
  assign push_data   = hold;

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold <= cls;
    end
  end

endmodule

[rtl/mrrc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrc_queue: command queue
// Short FIFO between the front and back parts so each can stall on its own.
// ----------------------------------------------------------------------------
module mrrc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mrrc_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output mrrc_pkg::cmd_t head
);

  localparam int DEPTH = mrrc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mrrc_pkg::cmd_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/mrrc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrc_div: speed divider
// Restoring divider, one quotient bit a cycle: scale constant divided by the
// history sum, saturated to the speed width. A zero sum gives all ones and
// so saturates.
// ----------------------------------------------------------------------------
module mrrc_div #(
  parameter int HISTORY_LEN = mrrc_pkg::HISTORY_LEN_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         start,
  input  logic [mrrc_pkg::RTIME_W+$clog2(HISTORY_LEN)-1:0] divisor,
  output mrrc_pkg::div_rsp_t                           rsp
);

  localparam int SUM_W  = mrrc_pkg::RTIME_W + $clog2(HISTORY_LEN);
  localparam int DQ_W   = mrrc_pkg::DIVIDEND_W;
  localparam int STEP_W = $clog2(DQ_W);
  localparam logic [DQ_W-1:0] NUM =
    DQ_W'(64'(HISTORY_LEN) * mrrc_pkg::SPEED_SCALE);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  dvs;
  logic [DQ_W-1:0]   dq;

  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    diff;
  logic              ge;

  // one restoring step
  always_comb begin
    trial = {rem, dq[DQ_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DQ_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      dq  <= NUM;
    end else if (busy) begin
      rem <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      dq  <= {dq[DQ_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = (dq > DQ_W'(mrrc_pkg::SPEED_MAX)) ? mrrc_pkg::SPEED_MAX
                                                      : dq[mrrc_pkg::SPEED_W-1:0];

endmodule

[rtl/mrrc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrc_back: execution stage
// Pops classified items, advances the timers, runs arming and pulse detection,
// counts revolutions, keeps the revolution time history and its running sum,
// and drives the result register. A revolution waits for the divider.
// ----------------------------------------------------------------------------
module mrrc_back #(
  parameter int HISTORY_LEN = mrrc_pkg::HISTORY_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mrrc_pkg::cfg_t        cfg,
  input  logic                  head_valid,
  input  mrrc_pkg::cmd_t        head,
  output logic                  pop,
  mrrc_out_if.source            out_ch
);

  localparam int SUM_W = mrrc_pkg::RTIME_W + $clog2(HISTORY_LEN);
  localparam int PT_W  = mrrc_pkg::PTIME_W;
  localparam int RT_W  = mrrc_pkg::RTIME_W;
  localparam int RV_W  = mrrc_pkg::REV_W;
  localparam int PP_W  = mrrc_pkg::PPR_W;
  localparam logic [SUM_W-1:0] SUM_RESET =
    SUM_W'(64'(HISTORY_LEN) * 64'hFFFF_FFFF);

  mrrc_pkg::back_state_t state, state_next;

  // block state
  logic                        armed;
  logic [PP_W-1:0]             pulse_count;
  logic [PT_W-1:0]             since_pulse;
  logic [RT_W-1:0]             since_rev;
  logic [RV_W-1:0]             rev_total;
  logic [RV_W-1:0]             rev_at_last_read;
  logic [RT_W-1:0]             hist [HISTORY_LEN];
  logic [SUM_W-1:0]            hist_sum;
  logic [mrrc_pkg::SPEED_W-1:0] speed;

  // result register
  logic                 out_valid;
  mrrc_pkg::out_item_t  out_reg;

  // step results
  logic [PT_W:0]        sp_add;
  logic [RT_W:0]        sr_add;
  logic [PT_W-1:0]      sp;
  logic [RT_W-1:0]      sr;
  logic                 timeout;
  logic                 fire;
  logic [PP_W-1:0]      pc_inc;
  logic                 rev_now;
  logic                 is_read;
  logic [SUM_W-1:0]     sum_next;
  logic [RV_W-1:0]      total_next;

  // control
  logic                 out_free;
  logic                 div_start;
  logic                 load_out;
  logic                 load_div;
  mrrc_pkg::div_rsp_t   div_rsp;

  // sample step arithmetic
  always_comb begin
    is_read  = (head.kind == mrrc_pkg::CMD_READ);
    sp_add   = {1'b0, since_pulse} + (PT_W + 1)'(head.elapsed_us);
    sr_add   = {1'b0, since_rev} + (RT_W + 1)'(head.elapsed_us);
    sp       = sp_add[PT_W] ? '1 : sp_add[PT_W-1:0];
    sr       = sr_add[RT_W] ? '1 : sr_add[RT_W-1:0];
    timeout  = sp > cfg.stop_timeout_us;
    fire     = (armed || (head.below_thr && (sp > PT_W'(cfg.pulse_ignore_us))))
               && head.above_zero;
    pc_inc   = pulse_count + PP_W'(1);
    rev_now  = !is_read && fire && (pc_inc >= cfg.pulses_per_rev);
    sum_next = hist_sum - SUM_W'(hist[HISTORY_LEN-1]) + SUM_W'(sr);
    total_next = rev_now ? rev_total + RV_W'(1) : rev_total;
  end

  assign out_free = !out_valid || out_ch.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mrrc_pkg::BK_RUN: begin
        if (head_valid && out_free && rev_now) begin
          state_next = mrrc_pkg::BK_DIV;
        end
      end
      mrrc_pkg::BK_DIV: begin
        if (div_rsp.done) begin
          state_next = mrrc_pkg::BK_RUN;
        end
      end
    endcase
  end

  // control outputs
  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    load_div  = 1'b0;
    unique case (state)
      mrrc_pkg::BK_RUN: begin
        pop       = head_valid && out_free;
        div_start = pop && rev_now;
        load_out  = pop && !rev_now;
      end
      mrrc_pkg::BK_DIV: begin
        load_div = div_rsp.done;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrrc_pkg::BK_RUN;
    end else begin
      state <= state_next;
    end
  end

  // state update on each popped item
  always_ff @(posedge clk) begin
    if (rst) begin
      armed            <= 1'b0;
      pulse_count      <= '0;
      since_pulse      <= '0;
      since_rev        <= '0;
      rev_total        <= '0;
      rev_at_last_read <= '0;
      hist_sum         <= SUM_RESET;
      speed            <= '0;
      for (int i = 0; i < HISTORY_LEN; i++) begin
        hist[i] <= '1;
      end
    end else begin
      if (pop) begin
        if (is_read) begin
          rev_at_last_read <= rev_total;
        end else begin
          since_rev <= rev_now ? '0 : sr;
          if (timeout) begin
            speed <= '0;
          end
          if (fire) begin
            armed       <= 1'b0;
            since_pulse <= '0;
            pulse_count <= rev_now ? '0 : pc_inc;
          end else begin
            armed       <= armed || (head.below_thr &&
                                     (sp > PT_W'(cfg.pulse_ignore_us)));
            since_pulse <= sp;
          end
          if (rev_now) begin
            rev_total <= total_next;
            hist_sum  <= sum_next;
            for (int i = HISTORY_LEN - 1; i >= 1; i--) begin
              hist[i] <= hist[i-1];
            end
            hist[0] <= sr;
          end
        end
      end
      if (load_div) begin
        speed <= div_rsp.quot;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out || load_div) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_reg.total_revs      <= rev_total;
      out_reg.revs_since_read <= rev_total - rev_at_last_read;
      out_reg.speed_rps_q8    <= (!is_read && timeout) ? '0 : speed;
      out_reg.pulse_seen      <= !is_read && fire;
      out_reg.rev_done        <= 1'b0;
    end else if (div_start) begin
      out_reg.total_revs      <= total_next;
      out_reg.revs_since_read <= total_next - rev_at_last_read;
      out_reg.pulse_seen      <= 1'b1;
      out_reg.rev_done        <= 1'b1;
    end else if (load_div) begin
      out_reg.speed_rps_q8    <= div_rsp.quot;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_reg;

  mrrc_div #(
    .HISTORY_LEN (HISTORY_LEN)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (sum_next),
    .rsp     (div_rsp)
  );

endmodule

[rtl/motor_ripple_rotation_counter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_ripple_rotation_counter_core: revolution counter from current ripple
// Counts ripple pulses in pre-filtered motor current samples, derives
// revolutions and an averaged speed, and serves read-and-clear requests.
// ----------------------------------------------------------------------------
// Each item gives exactly one result. An item passes the input register and
// the two-entry queue and is executed in the back stage, so samples and reads
// that complete no revolution flow at one item a cycle once the pipe is full
// and while the receiver takes results, each result registered before it is
// offered. An item that completes a revolution holds the execution stage
// until the 32-step restoring divider has turned the revolution time history
// sum into speed; the queue keeps taking items meanwhile. Configuration is
// written through cfg_we, cfg_index and cfg_data and must only change while
// the block is idle.
module motor_ripple_rotation_counter_core #(
  parameter int HISTORY_LEN = mrrc_pkg::HISTORY_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  mrrc_in_if.sink                             in_ch,
  mrrc_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [mrrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mrrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mrrc_pkg::cfg_t cfg;
  logic           push;
  mrrc_pkg::cmd_t push_data;
  logic           full;
  logic           pop;
  logic           head_valid;
  mrrc_pkg::cmd_t head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ripple_threshold_ma <= mrrc_pkg::THR_RESET;
      cfg.pulse_ignore_us     <= mrrc_pkg::IGNORE_RESET;
      cfg.pulses_per_rev      <= mrrc_pkg::PPR_RESET;
      cfg.stop_timeout_us     <= mrrc_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrrc_pkg::CFG_RIPPLE_THRESHOLD:
          cfg.ripple_threshold_ma <= cfg_data[mrrc_pkg::THR_W-1:0];
        mrrc_pkg::CFG_PULSE_IGNORE:
          cfg.pulse_ignore_us     <= cfg_data[mrrc_pkg::IGNORE_W-1:0];
        mrrc_pkg::CFG_PULSES_PER_REV:
          cfg.pulses_per_rev      <= cfg_data[mrrc_pkg::PPR_W-1:0];
        mrrc_pkg::CFG_STOP_TIMEOUT:
          cfg.stop_timeout_us     <= cfg_data[mrrc_pkg::TIMEOUT_W-1:0];
      endcase
    end
  end

  mrrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  mrrc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mrrc_back #(
    .HISTORY_LEN (HISTORY_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

[bench/motor_ripple_rotation_counter_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_ripple_rotation_counter_core_test: bench for the ripple rotation counter
// Sends sample and read items over the valid/ready channels with random gaps
// and stalls, and compares every result with a cycle-free behavioural copy of
// the counter. A directed table covers the extremes and corner cases first,
// then random pulse sequences run under several register settings.
// ----------------------------------------------------------------------------
module motor_ripple_rotation_counter_core_test;
  import mrrc_pkg::*;

  localparam int HALF_PERIOD   = 1;
  localparam int HIST_DEPTH    = HISTORY_LEN_DEF;
  localparam longint unsigned SPEED_NUM = 64'd256000000 * HIST_DEPTH;
  localparam int MAX_WAIT      = 13;
  localparam int HOLD_CYCLES   = 240;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 60;
  localparam int NUM_PHASES    = 8;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_FIXED,
    ROW_CFG
  } row_kind_t;

  typedef enum logic [1:0] {
    SHAPE_DIP,
    SHAPE_PEAK,
    SHAPE_READ,
    SHAPE_NOISE
  } item_shape_t;

  typedef struct {
    row_kind_t              kind;
    in_item_t               item;
    out_item_t              want;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mrrc_in_if  in_ch ();
  mrrc_out_if out_ch ();

  motor_ripple_rotation_counter_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // register copy
  logic signed [THR_W-1:0] set_thr;
  logic [IGNORE_W-1:0]     set_ignore;
  logic [PPR_W-1:0]        set_ppr;
  logic [TIMEOUT_W-1:0]    set_timeout;

  // counter state copy
  logic                    cnt_armed;
  logic [PPR_W-1:0]        cnt_pulses;
  logic [PTIME_W-1:0]      cnt_since_pulse;
  logic [RTIME_W-1:0]      cnt_since_rev;
  logic [REV_W-1:0]        cnt_revs;
  logic [REV_W-1:0]        cnt_revs_read;
  logic [RTIME_W-1:0]      cnt_hist [HIST_DEPTH];
  logic [SPEED_W-1:0]      cnt_speed;

  out_item_t pending_results [$];
  dir_row_t  dir_rows [$];
  out_item_t oldest_result;
  int        mismatches   = 0;
  int        results_seen = 0;
  bit        src_idle     = 1'b1;
  bit        snk_idle     = 1'b1;
  bit        hold_req     = 1'b0;

  function automatic void reset_counter_model();
    set_thr         = THR_RESET;
    set_ignore      = IGNORE_RESET;
    set_ppr         = PPR_RESET;
    set_timeout     = TIMEOUT_RESET;
    cnt_armed       = 1'b0;
    cnt_pulses      = '0;
    cnt_since_pulse = '0;
    cnt_since_rev   = '0;
    cnt_revs        = '0;
    cnt_revs_read   = '0;
    foreach (cnt_hist[i]) cnt_hist[i] = '1;
    cnt_speed       = '0;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_RIPPLE_THRESHOLD: set_thr    = val[THR_W-1:0];
      CFG_PULSE_IGNORE:     set_ignore = val[IGNORE_W-1:0];
      CFG_PULSES_PER_REV:   set_ppr    = val[PPR_W-1:0];
      default:              set_timeout = val[TIMEOUT_W-1:0];
    endcase
  endfunction

  // averaged speed from the revolution time history, saturated
  function automatic logic [SPEED_W-1:0] speed_from_history();
    longint unsigned sum;
    longint unsigned quot;
    sum = 0;
    foreach (cnt_hist[i]) sum += cnt_hist[i];
    if (sum == 0) return SPEED_MAX;
    quot = SPEED_NUM / sum;
    return (quot > SPEED_MAX) ? SPEED_MAX : quot[SPEED_W-1:0];
  endfunction

  // advance the counter copy by one item and give its result
  function automatic out_item_t predict_counter_step(in_item_t it);
    out_item_t        res;
    logic [PTIME_W:0] t_pulse;
    logic [RTIME_W:0] t_rev;
    logic [REV_W-1:0] since_read;
    res        = '0;
    since_read = cnt_revs - cnt_revs_read;
    if (it.op == OP_READ) begin
      cnt_revs_read = cnt_revs;
    end else begin
      t_pulse = {1'b0, cnt_since_pulse} + (PTIME_W+1)'(it.elapsed_us);
      cnt_since_pulse = t_pulse[PTIME_W] ? '1 : t_pulse[PTIME_W-1:0];
      t_rev = {1'b0, cnt_since_rev} + (RTIME_W+1)'(it.elapsed_us);
      cnt_since_rev = t_rev[RTIME_W] ? '1 : t_rev[RTIME_W-1:0];
      if (cnt_since_pulse > set_timeout) cnt_speed = '0;
      if ($signed(it.ripple_ma) < set_thr && cnt_since_pulse > set_ignore) cnt_armed = 1'b1;
      if (cnt_armed && $signed(it.ripple_ma) > 16'sd0) begin
        res.pulse_seen  = 1'b1;
        cnt_armed       = 1'b0;
        cnt_since_pulse = '0;
        cnt_pulses      = cnt_pulses + 1'b1;
        // a lowered or zero setting completes the revolution at once
        if (cnt_pulses >= set_ppr) begin
          res.rev_done = 1'b1;
          cnt_pulses   = '0;
          cnt_revs     = cnt_revs + 1'b1;
          for (int i = HIST_DEPTH - 1; i >= 1; i--) cnt_hist[i] = cnt_hist[i-1];
          cnt_hist[0]   = cnt_since_rev;
          cnt_since_rev = '0;
          cnt_speed     = speed_from_history();
        end
      end
      since_read = cnt_revs - cnt_revs_read;
    end
    res.total_revs      = cnt_revs;
    res.revs_since_read = since_read;
    res.speed_rps_q8    = cnt_speed;
    return res;
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             results_seen, what, got, want);
    mismatches++;
  endtask

  // directed table rows
  function automatic void row_item(logic op, int ripple, int period);
    dir_row_t r;
    r.kind            = ROW_ITEM;
    r.item.op         = op;
    r.item.ripple_ma  = 16'(ripple);
    r.item.elapsed_us = 16'(period);
    r.want            = '0;
    r.reg_idx         = '0;
    r.reg_val         = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_fixed(logic op, int ripple, int period, out_item_t want);
    row_item(op, ripple, period);
    dir_rows[$].kind = ROW_FIXED;
    dir_rows[$].want = want;
  endfunction

  function automatic void row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r.kind    = ROW_CFG;
    r.item    = '0;
    r.want    = '0;
    r.reg_idx = idx;
    r.reg_val = val;
    dir_rows.push_back(r);
  endfunction

  // random item of a given shape, biased by the current settings
  function automatic in_item_t random_item(item_shape_t shape);
    in_item_t it;
    int       span;
    int       offset;
    int       lim;
    it.op         = OP_SAMPLE;
    it.ripple_ma  = 16'($urandom);
    it.elapsed_us = 16'($urandom);
    lim = int'(set_ignore) + int'(set_ignore) / 2 + 64;
    if (lim > 65535) lim = 65535;
    case (shape)
      SHAPE_DIP: begin
        span = int'(set_thr) + 32768;
        if (span > 0) begin
          offset = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span - 1)
                                                : $urandom_range(0, (span > 400) ? 399 : span - 1);
          it.ripple_ma = 16'(int'(set_thr) - 1 - offset);
        end
        it.elapsed_us = 16'($urandom_range(0, lim));
      end
      SHAPE_PEAK: begin
        it.ripple_ma  = 16'($urandom_range(1, 32767));
        it.elapsed_us = 16'($urandom_range(0, lim / 4));
      end
      SHAPE_READ: it.op = OP_READ;
      default: ;
    endcase
    // nothing can arm at the floor threshold: run the time counters into saturation
    if (set_thr == 16'sh8000 && it.op == OP_SAMPLE) it.elapsed_us = '1;
    return it;
  endfunction

  task automatic send_item(in_item_t it, bit fixed, out_item_t want);
    int        gap;
    out_item_t pred;
    gap = src_idle ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = predict_counter_step(it);
    pending_results.push_back(fixed ? want : pred);
  endtask

  task automatic send_random_group(output int count);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      send_item(random_item(SHAPE_DIP), 1'b0, '0);
      send_item(random_item(SHAPE_PEAK), 1'b0, '0);
      count = 2;
    end else begin
      send_item(random_item((pick == 7) ? SHAPE_READ : SHAPE_NOISE), 1'b0, '0);
      count = 1;
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_register(idx, val);
    @(posedge clk);
  endtask

  task automatic write_settings(int thr, int ign, int ppr, int tmo);
    wait_idle();
    set_register(CFG_RIPPLE_THRESHOLD, {8'h00, 16'(thr)});
    set_register(CFG_PULSE_IGNORE, CFG_DATA_W'(16'(ign)));
    set_register(CFG_PULSES_PER_REV, CFG_DATA_W'(6'(ppr)));
    set_register(CFG_STOP_TIMEOUT, CFG_DATA_W'(tmo));
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch("result with none pending", out_ch.data.total_revs, 0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_ch.data.total_revs !== oldest_result.total_revs)
          flag_mismatch("total_revs", out_ch.data.total_revs, oldest_result.total_revs);
        if (out_ch.data.revs_since_read !== oldest_result.revs_since_read)
          flag_mismatch("revs_since_read", out_ch.data.revs_since_read,
                        oldest_result.revs_since_read);
        if (out_ch.data.speed_rps_q8 !== oldest_result.speed_rps_q8)
          flag_mismatch("speed_rps_q8", out_ch.data.speed_rps_q8, oldest_result.speed_rps_q8);
        if (out_ch.data.pulse_seen !== oldest_result.pulse_seen)
          flag_mismatch("pulse_seen", out_ch.data.pulse_seen, oldest_result.pulse_seen);
        if (out_ch.data.rev_done !== oldest_result.rev_done)
          flag_mismatch("rev_done", out_ch.data.rev_done, oldest_result.rev_done);
      end
    end
  end

  // result receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = snk_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // run time limit
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus
  initial begin
    int  phase_len;
    int  sent;
    int  count;
    bit  paused;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    reset_counter_model();

    // directed table: reset settings first, then the corner cases
    row_fixed(OP_READ, -1, 65535, '0);
    row_fixed(OP_SAMPLE, -32768, 0, '0);
    row_fixed(OP_SAMPLE, 32767, 65535, '0);
    row_fixed(OP_SAMPLE, -32768, 65535, '0);
    row_fixed(OP_SAMPLE, 32767, 0, out_item_t'{total_revs: 32'd0, revs_since_read: 32'd0,
                                               speed_rps_q8: 24'd0, pulse_seen: 1'b1,
                                               rev_done: 1'b0});
    row_item(OP_SAMPLE, -31, 501);
    row_item(OP_SAMPLE, -30, 10);
    row_item(OP_SAMPLE, 0, 0);
    row_item(OP_SAMPLE, 1, 0);
    // positive threshold: arm and fire on one sample, one pulse a revolution
    row_cfg(CFG_RIPPLE_THRESHOLD, 24'd100);
    row_cfg(CFG_PULSE_IGNORE, 24'd0);
    row_cfg(CFG_PULSES_PER_REV, 24'd1);
    repeat (5) row_item(OP_SAMPLE, 50, 1);
    // zero pulses per revolution behaves as one
    row_cfg(CFG_PULSES_PER_REV, 24'd0);
    row_item(OP_SAMPLE, 50, 1);
    // lowered to the running pulse count
    row_cfg(CFG_PULSES_PER_REV, 24'd63);
    row_item(OP_SAMPLE, 50, 1);
    row_item(OP_SAMPLE, 50, 1);
    row_cfg(CFG_PULSES_PER_REV, 24'd2);
    row_item(OP_SAMPLE, 50, 1);
    // zero stop timeout clears the speed
    row_cfg(CFG_STOP_TIMEOUT, 24'd0);
    row_item(OP_SAMPLE, 0, 5);
    row_item(OP_READ, 0, 0);
    row_cfg(CFG_RIPPLE_THRESHOLD, 24'h008000);
    row_item(OP_SAMPLE, -32768, 100);
    row_item(OP_SAMPLE, 1, 0);
    row_item(OP_READ, 32767, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          wait_idle();
          set_register(dir_rows[i].reg_idx, dir_rows[i].reg_val);
        end
        default: send_item(dir_rows[i].item, dir_rows[i].kind == ROW_FIXED, dir_rows[i].want);
      endcase
    end

    // random phases under varied settings
    paused = 1'b0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: write_settings(-30, 500, 6, 100000);
        1: write_settings(0, 0, 1, 0);
        2: write_settings(-32768, 65535, 63, 24'hFFFFFF);
        3: write_settings(200, 0, 0, 50000);
        4: write_settings(-$urandom_range(0, 2000), $urandom_range(0, 3000),
                          $urandom_range(1, 8), $urandom_range(0, 24'hFFFFFF));
        5: write_settings(-1, 1, 2, 5000);
        6: write_settings(-$urandom_range(0, 32768), $urandom_range(0, 65535),
                          $urandom_range(0, 63), $urandom);
        default: write_settings(-100, 100, 3, 24'hFFFFFF);
      endcase
      src_idle  = (ph % 3 != 1);
      snk_idle  = (ph % 4 != 2);
      phase_len = (ph == 2) ? 320 : 60;
      // long receiver hold-off while the sender keeps offering items
      if (ph == 4) hold_req = 1'b1;
      sent = 0;
      while (sent < phase_len) begin
        if (ph == 5 && sent >= 30 && !paused) begin
          wait_idle();
          paused = 1'b1;
        end
        send_random_group(count);
        sent += count;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
